FILE: rtl/pdab_pkg.sv
// Shared widths, constants and pipeline payload types for the PWM duty block.
package pdab_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned PHASES     = 3;
  localparam int unsigned DIV_BITS   = 2;
  localparam int unsigned DIV_STAGES = DATA_W / DIV_BITS;

  localparam logic [15:0] SQRT3_HALF_Q16 = 16'd56756;
  localparam logic [15:0] MOD_MIN_Q15    = 16'd3277;
  localparam logic [15:0] MOD_MAX_Q15    = 16'd32768;
  localparam logic [15:0] HALF_Q15       = 16'd16384;
  localparam logic [15:0] BUS_MIN_Q8     = 16'd256;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_LOW_BUS  = 1'b1;

  // one phase in flight through the divider: dq holds the remaining
  // dividend bits on top and collects quotient bits from the bottom
  typedef struct packed {
    logic        neg;
    logic        sat;
    logic [15:0] rem;
    logic [15:0] dq;
  } pdab_lane_t;

  typedef struct packed {
    pdab_lane_t [PHASES-1:0] lane;
    logic [15:0]             bus;
    logic                    low_bus;
  } pdab_work_t;

endpackage

FILE: rtl/pdab_if.sv
// Valid/ready channel interfaces for the voltage vector input and the duty result.
interface pdab_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] volt_alpha;
  logic signed [15:0] volt_beta;
  logic [15:0]        bus_voltage;

  modport source (output valid, output volt_alpha, output volt_beta,
                  output bus_voltage, input ready);
  modport sink   (input valid, input volt_alpha, input volt_beta,
                  input bus_voltage, output ready);
endinterface

interface pdab_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty_a;
  logic [15:0] duty_b;
  logic [15:0] duty_c;
  logic        status;

  modport source (output valid, output duty_a, output duty_b, output duty_c,
                  output status, input ready);
  modport sink   (input valid, input duty_a, input duty_b, input duty_c,
                  input status, output ready);
endinterface

FILE: rtl/pwm_duty_from_alpha_beta_top.sv
// Top level: three-phase PWM duty from an alpha/beta voltage vector and bus voltage.
// Pipeline stages: 4 transform, 8 divider of 2 bits, 1 output.
// Throughput: one item per cycle while the output side is ready; each stage stalls only
//   when it is full and the stage after it is blocked, so bubbles are squeezed out.
// Reset clears all valid bits and sets the modulation limit to full scale.
module pwm_duty_from_alpha_beta_top (
  input  logic        clk,
  input  logic        rst_n,
  pdab_in_if.sink     in_ch,
  pdab_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic                 dv_vld  [pdab_pkg::DIV_STAGES+1];
  logic                 dv_rdy  [pdab_pkg::DIV_STAGES+1];
  pdab_pkg::pdab_work_t dv_data [pdab_pkg::DIV_STAGES+1];

  pdab_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_valid (dv_vld[0]),
    .out_ready (dv_rdy[0]),
    .out_data  (dv_data[0])
  );

  for (genvar g = 0; g < pdab_pkg::DIV_STAGES; g++) begin : g_div
    pdab_div_stage u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv_vld[g]),
      .in_ready  (dv_rdy[g]),
      .in_data   (dv_data[g]),
      .out_valid (dv_vld[g+1]),
      .out_ready (dv_rdy[g+1]),
      .out_data  (dv_data[g+1])
    );
  end

  pdab_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_vld[pdab_pkg::DIV_STAGES]),
    .in_ready  (dv_rdy[pdab_pkg::DIV_STAGES]),
    .in_data   (dv_data[pdab_pkg::DIV_STAGES]),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );

endmodule

FILE: rtl/pdab_front.sv
// Inverse Clarke transform and divider setup: four pipeline stages.
module pdab_front (
  input  logic                clk,
  input  logic                rst_n,
  pdab_in_if.sink             in_ch,
  output logic                out_valid,
  input  logic                out_ready,
  output pdab_pkg::pdab_work_t out_data
);

  localparam int unsigned NSTG = 4;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] adv;

  logic signed [15:0] alpha1_r;
  logic signed [32:0] pb1_r;
  logic [15:0]        bus1_r;
  logic signed [32:0] pb_nxt;

  logic signed [32:0] v2_r   [pdab_pkg::PHASES];
  logic signed [32:0] v2_nxt [pdab_pkg::PHASES];
  logic [15:0]        bus2_r;
  logic signed [32:0] a_ext;
  logic signed [32:0] ah;

  logic [pdab_pkg::PHASES-1:0] neg3_r;
  logic [pdab_pkg::PHASES-1:0] neg3_nxt;
  logic [32:0]        num3_r   [pdab_pkg::PHASES];
  logic [32:0]        num3_nxt [pdab_pkg::PHASES];
  logic [15:0]        bus3_r;
  logic [32:0]        h;

  pdab_pkg::pdab_work_t work4_r;
  pdab_pkg::pdab_work_t work4_nxt;

  // each stage moves when it is empty or the next one takes its item
  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ch.ready = adv[0];

  // stage 1: beta * sqrt3/2
  assign pb_nxt = $signed(in_ch.volt_beta) * $signed({1'b0, pdab_pkg::SQRT3_HALF_Q16});

  // stage 2: phase voltages at 2^-24 V
  always_comb begin
    a_ext     = 33'(alpha1_r);
    ah        = a_ext <<< 15;
    v2_nxt[0] = a_ext <<< 16;
    v2_nxt[1] = pb1_r - ah;
    v2_nxt[2] = -ah - pb1_r;
  end

  // stage 3: magnitude plus half the divisor, in one add
  always_comb begin
    h = {18'd0, bus2_r[15:1]};
    for (int p = 0; p < pdab_pkg::PHASES; p++) begin
      neg3_nxt[p] = v2_r[p][32];
      num3_nxt[p] = neg3_nxt[p] ? (h - $unsigned(v2_r[p])) : ($unsigned(v2_r[p]) + h);
    end
  end

  // stage 4: quotient above 16 bits only saturates the duty
  always_comb begin
    work4_nxt.bus     = bus3_r;
    work4_nxt.low_bus = bus3_r < pdab_pkg::BUS_MIN_Q8;
    for (int p = 0; p < pdab_pkg::PHASES; p++) begin
      work4_nxt.lane[p].neg = neg3_r[p];
      work4_nxt.lane[p].sat = num3_r[p][32:16] >= {1'b0, bus3_r};
      work4_nxt.lane[p].rem = num3_r[p][31:16];
      work4_nxt.lane[p].dq  = num3_r[p][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_ch.valid;
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      alpha1_r <= in_ch.volt_alpha;
      pb1_r    <= pb_nxt;
      bus1_r   <= in_ch.bus_voltage;
    end
    if (adv[1]) begin
      v2_r   <= v2_nxt;
      bus2_r <= bus1_r;
    end
    if (adv[2]) begin
      neg3_r <= neg3_nxt;
      num3_r <= num3_nxt;
      bus3_r <= bus2_r;
    end
    if (adv[3]) begin
      work4_r <= work4_nxt;
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_data  = work4_r;

endmodule

FILE: rtl/pdab_div_stage.sv
// One restoring-division stage: DIV_BITS quotient bits for each phase.
module pdab_div_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pdab_pkg::pdab_work_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pdab_pkg::pdab_work_t out_data
);

  logic                 vld_r;
  pdab_pkg::pdab_work_t work_r;
  pdab_pkg::pdab_work_t work_nxt;

  logic [15:0] rem;
  logic [15:0] dq;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        take;

  assign in_ready = !vld_r || out_ready;

  always_comb begin
    work_nxt = in_data;
    rem      = '0;
    dq       = '0;
    trial    = '0;
    diff     = '0;
    take     = 1'b0;
    for (int p = 0; p < pdab_pkg::PHASES; p++) begin
      rem = in_data.lane[p].rem;
      dq  = in_data.lane[p].dq;
      for (int s = 0; s < pdab_pkg::DIV_BITS; s++) begin
        trial = {rem, dq[15]};
        diff  = trial - {1'b0, in_data.bus};
        take  = trial >= {1'b0, in_data.bus};
        rem   = take ? diff[15:0] : trial[15:0];
        dq    = {dq[14:0], take};
      end
      work_nxt.lane[p].rem = rem;
      work_nxt.lane[p].dq  = dq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      work_r <= work_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = work_r;

  // partial remainder stays below the divisor unless the quotient saturates
  a_rem_below_bus_0 : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !work_r.lane[0].sat |-> work_r.lane[0].rem < work_r.bus)
    else $error("phase a remainder not below bus");
  a_rem_below_bus_1 : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !work_r.lane[1].sat |-> work_r.lane[1].rem < work_r.bus)
    else $error("phase b remainder not below bus");
  a_rem_below_bus_2 : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !work_r.lane[2].sat |-> work_r.lane[2].rem < work_r.bus)
    else $error("phase c remainder not below bus");

endmodule

FILE: rtl/pdab_back.sv
// Duty offset, modulation clamp, low-bus zeroing and output register; holds the limit register.
module pdab_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pdab_pkg::pdab_work_t in_data,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  pdab_out_if.source           out_ch
);

  logic [15:0] lo_r;
  logic [15:0] hi_r;
  logic [15:0] lo_nxt;
  logic [15:0] hi_nxt;
  logic [15:0] mod;
  logic [16:0] half;

  logic        out_valid_r;
  logic [15:0] duty_r   [pdab_pkg::PHASES];
  logic [15:0] duty_nxt [pdab_pkg::PHASES];
  logic        status_r;
  logic [15:0] q;
  logic signed [17:0] d;

  // limits are worked out once per register write
  always_comb begin
    mod = cfg_wdata;
    if (cfg_wdata < pdab_pkg::MOD_MIN_Q15) mod = pdab_pkg::MOD_MIN_Q15;
    if (cfg_wdata > pdab_pkg::MOD_MAX_Q15) mod = pdab_pkg::MOD_MAX_Q15;
    half   = ({1'b0, mod} + 17'd1) >> 1;
    lo_nxt = pdab_pkg::HALF_Q15 - half[15:0];
    hi_nxt = pdab_pkg::HALF_Q15 + half[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= '0;
      hi_r <= pdab_pkg::MOD_MAX_Q15;
    end else if (cfg_we) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  always_comb begin
    q = '0;
    d = '0;
    for (int p = 0; p < pdab_pkg::PHASES; p++) begin
      q = in_data.lane[p].sat ? '1 : in_data.lane[p].dq;
      d = in_data.lane[p].neg ? ($signed({2'b00, pdab_pkg::HALF_Q15}) - $signed({2'b00, q}))
                              : ($signed({2'b00, pdab_pkg::HALF_Q15}) + $signed({2'b00, q}));
      if (d < $signed({2'b00, lo_r})) begin
        duty_nxt[p] = lo_r;
      end else if (d > $signed({2'b00, hi_r})) begin
        duty_nxt[p] = hi_r;
      end else begin
        duty_nxt[p] = d[15:0];
      end
      if (in_data.low_bus) duty_nxt[p] = '0;
    end
  end

  assign in_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      duty_r   <= duty_nxt;
      status_r <= in_data.low_bus ? pdab_pkg::STATUS_LOW_BUS : pdab_pkg::STATUS_OK;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.duty_a = duty_r[0];
  assign out_ch.duty_b = duty_r[1];
  assign out_ch.duty_c = duty_r[2];
  assign out_ch.status = status_r;

  // limits are always symmetric about one half
  a_limits_symmetric : assert property (@(posedge clk) disable iff (!rst_n)
    (17'(lo_r) + 17'(hi_r)) == {pdab_pkg::HALF_Q15, 1'b0})
    else $error("duty limits not centered");

  a_duty_a_in_limits : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == pdab_pkg::STATUS_OK |-> duty_r[0] >= lo_r && duty_r[0] <= hi_r)
    else $error("phase a duty outside limits");

  a_low_bus_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == pdab_pkg::STATUS_LOW_BUS
      |-> duty_r[0] == '0 && duty_r[1] == '0 && duty_r[2] == '0)
    else $error("low bus result with nonzero duty");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the alpha/beta to three-phase PWM duty block.
module tb_top;

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic        status;
  } duty_set_t;

  typedef struct {
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [15:0]        bus;
    bit                 typed;
    duty_set_t          want;
  } vec_row_t;

  localparam int NUM_DIR     = 20;
  localparam int NUM_PHASES  = 9;
  localparam int PHASE_ITEMS = 170;
  localparam int DRAIN_CYC   = 30;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;

  pdab_in_if  in_if();
  pdab_out_if out_if();

  pwm_duty_from_alpha_beta_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  duty_set_t   duty_q[$];
  logic [15:0] mod_reg;
  int          send_pct;
  int          recv_pct;
  bit          drain_req;
  int          n_items;
  int          n_checked;
  int          n_low_bus;
  int          n_errors;
  int          n_settings;

  vec_row_t dir_rows [NUM_DIR];
  logic [15:0] mod_set [NUM_PHASES];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [15:0] phase_duty_of(longint v, longint bs, longint lo, longint hi);
    longint mag;
    longint q;
    longint d;
    mag = (v < 0) ? -v : v;
    q   = (mag + bs / 2) / bs;
    d   = longint'(pdab_pkg::HALF_Q15) + ((v < 0) ? -q : q);
    if (d < lo) d = lo;
    if (d > hi) d = hi;
    return d[15:0];
  endfunction

  function automatic duty_set_t calc_duties(logic signed [15:0] alpha, logic signed [15:0] beta,
                                            logic [15:0] bus, logic [15:0] mod);
    longint al;
    longint be;
    longint bs;
    longint md;
    longint half;
    longint lo;
    longint hi;
    longint kb;
    duty_set_t r;
    al = alpha;
    be = beta;
    bs = longint'(bus);
    md = longint'(mod);
    kb = longint'(pdab_pkg::SQRT3_HALF_Q16);
    if (bs < longint'(pdab_pkg::BUS_MIN_Q8)) begin
      r.duty_a = '0;
      r.duty_b = '0;
      r.duty_c = '0;
      r.status = pdab_pkg::STATUS_LOW_BUS;
      return r;
    end
    if (md < longint'(pdab_pkg::MOD_MIN_Q15)) md = longint'(pdab_pkg::MOD_MIN_Q15);
    if (md > longint'(pdab_pkg::MOD_MAX_Q15)) md = longint'(pdab_pkg::MOD_MAX_Q15);
    half = (md + 1) / 2;
    lo   = longint'(pdab_pkg::HALF_Q15) - half;
    hi   = longint'(pdab_pkg::HALF_Q15) + half;
    // phase voltages at 2^-24 V
    r.duty_a = phase_duty_of(al * 65536, bs, lo, hi);
    r.duty_b = phase_duty_of(-al * 32768 + be * kb, bs, lo, hi);
    r.duty_c = phase_duty_of(-al * 32768 - be * kb, bs, lo, hi);
    r.status = pdab_pkg::STATUS_OK;
    return r;
  endfunction

  task automatic send_vector(logic signed [15:0] alpha, logic signed [15:0] beta,
                             logic [15:0] bus, bit typed, duty_set_t want);
    duty_set_t exp_set;
    exp_set = typed ? want : calc_duties(alpha, beta, bus, mod_reg);
    @(negedge clk);
    if (drain_req) begin
      drain_req = 1'b0;
      in_if.valid <= 1'b0;
      do @(negedge clk); while (duty_q.size() != 0);
    end
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.volt_alpha  <= alpha;
    in_if.volt_beta   <= beta;
    in_if.bus_voltage <= bus;
    do @(posedge clk); while (!in_if.ready);
    duty_q.push_back(exp_set);
    n_items++;
    if (bus < pdab_pkg::BUS_MIN_Q8) n_low_bus++;
  endtask

  task automatic send_random();
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [15:0]        bus;
    int                 kind;
    int                 lim;
    int unsigned        t;
    kind  = $urandom_range(99);
    alpha = 16'($urandom);
    beta  = 16'($urandom);
    if (kind < 6) begin
      bus = 16'($urandom_range(255));
    end else if (kind < 40) begin
      bus = 16'($urandom);
    end else begin
      // keep the vector near the unclamped range for this bus
      bus   = 16'($urandom_range(65535, 256));
      lim   = int'(bus) / 4;
      t     = $urandom_range(2 * lim);
      alpha = 16'(int'(t) - lim);
      t     = $urandom_range(2 * lim);
      beta  = 16'(int'(t) - lim);
    end
    send_vector(alpha, beta, bus, 1'b0, '0);
  endtask

  task automatic write_mod(logic [15:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    mod_reg = v;
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (duty_q.size() != 0) @(negedge clk);
  endtask

  // result side: random backpressure, compare against oldest prediction
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= !(recv_pct != 0 && $urandom_range(99) < recv_pct);
    end
  end

  always @(posedge clk) begin
    duty_set_t exp_set;
    duty_set_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.duty_a = out_if.duty_a;
      got.duty_b = out_if.duty_b;
      got.duty_c = out_if.duty_c;
      got.status = out_if.status;
      if (duty_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: unexpected result a=%0d b=%0d c=%0d status=%0d",
                   got.duty_a, got.duty_b, got.duty_c, got.status);
      end else begin
        exp_set = duty_q.pop_front();
        n_checked++;
        if (got.duty_a !== exp_set.duty_a || got.duty_b !== exp_set.duty_b ||
            got.duty_c !== exp_set.duty_c || got.status !== exp_set.status) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: result %0d exp a=%0d b=%0d c=%0d st=%0d got a=%0d b=%0d c=%0d st=%0d",
                     n_checked, exp_set.duty_a, exp_set.duty_b, exp_set.duty_c,
                     exp_set.status, got.duty_a, got.duty_b, got.duty_c, got.status);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", duty_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.volt_alpha  = '0;
    in_if.volt_beta   = '0;
    in_if.bus_voltage = '0;
    mod_reg           = pdab_pkg::MOD_MAX_Q15;
    send_pct          = 0;
    recv_pct          = 0;
    drain_req         = 1'b0;
    n_items           = 0;
    n_checked         = 0;
    n_low_bus         = 0;
    n_errors          = 0;
    n_settings        = 1;

    // expectations typed in assume full modulation: limits 0..32768
    dir_rows = '{
      '{16'sd0,       16'sd0,       16'd0,     1'b1,
        '{16'd0, 16'd0, 16'd0, pdab_pkg::STATUS_LOW_BUS}},
      '{16'sd32767,   16'sh8000,    16'd255,   1'b1,
        '{16'd0, 16'd0, 16'd0, pdab_pkg::STATUS_LOW_BUS}},
      '{16'sd0,       16'sd0,       16'd256,   1'b1,
        '{16'd16384, 16'd16384, 16'd16384, pdab_pkg::STATUS_OK}},
      '{16'sd0,       16'sd0,       16'd65535, 1'b1,
        '{16'd16384, 16'd16384, 16'd16384, pdab_pkg::STATUS_OK}},
      '{16'sd32767,   16'sd0,       16'd256,   1'b1,
        '{16'd32768, 16'd0, 16'd0, pdab_pkg::STATUS_OK}},
      '{16'sh8000,    16'sd0,       16'd256,   1'b1,
        '{16'd0, 16'd32768, 16'd32768, pdab_pkg::STATUS_OK}},
      '{16'sd0,       16'sd32767,   16'd256,   1'b1,
        '{16'd16384, 16'd32768, 16'd0, pdab_pkg::STATUS_OK}},
      '{16'sd0,       16'sh8000,    16'd256,   1'b1,
        '{16'd16384, 16'd0, 16'd32768, pdab_pkg::STATUS_OK}},
      '{16'sd32767,   16'sd32767,   16'd65535, 1'b0, '0},
      '{16'sh8000,    16'sh8000,    16'd65535, 1'b0, '0},
      '{16'sd1,       16'sd0,       16'd65535, 1'b0, '0},
      '{-16'sd1,      16'sd0,       16'd65535, 1'b0, '0},
      '{16'sd256,     16'sd256,     16'd4096,  1'b0, '0},
      '{-16'sd100,    16'sd300,     16'd1000,  1'b0, '0},
      '{16'sd16383,   -16'sd16384,  16'd65535, 1'b0, '0},
      '{16'sd100,     -16'sd100,    16'd256,   1'b0, '0},
      '{16'sd12345,   -16'sd23456,  16'd40000, 1'b0, '0},
      '{16'sh5555,    16'shAAAA,    16'hAAAA,  1'b0, '0},
      '{16'shAAAA,    16'sh5555,    16'h5555,  1'b0, '0},
      '{16'sd4000,    -16'sd3000,   16'd65535, 1'b0, '0}
    };

    // phase 0 runs on the reset value; the rest write the register
    mod_set = '{pdab_pkg::MOD_MAX_Q15, 16'd0, 16'hFFFF, 16'd3277, 16'd3276,
                16'd32767, 16'd32769, 16'd16385, 16'($urandom)};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_vector(dir_rows[i].alpha, dir_rows[i].beta, dir_rows[i].bus,
                  dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p != 0) begin
        write_mod(mod_set[p]);
        n_settings++;
      end
      case (p % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 55; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 55; end
        default: begin send_pct = 34; recv_pct = 34; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // one mid-phase pause until the pipeline has fully emptied
        if (p == 2 && k == PHASE_ITEMS / 2) drain_req = 1'b1;
        send_random();
      end
    end

    drain();
    repeat (DRAIN_CYC) @(posedge clk);
    if (duty_q.size() != 0) begin
      n_errors++;
      $display("ERROR: %0d results never arrived", duty_q.size());
    end

    $display("Run covered %0d items (%0d directed, %0d with bus below one volt) under %0d",
             n_items, NUM_DIR, n_low_bus, n_settings);
    $display("modulation settings and four pacing modes; %0d results checked, %0d errors",
             n_checked, n_errors);
    if (n_errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
